FILE: src/rpat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpat_pkg
// Shared widths, register indexes and reset values for the rotor period and
// angle tracker.
// ----------------------------------------------------------------------------
package rpat_pkg;

    // tick counter and captured period width
    localparam int COUNT_WIDTH = 24;

    // field widths
    localparam int DEB_W     = 16;
    localparam int OFS_W     = 9;
    localparam int PER_W     = 24;
    localparam int ANG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    // angle arithmetic
    localparam int TURN_W = 9;
    localparam int NUM_W  = COUNT_WIDTH + TURN_W;
    localparam int Q_W    = 10;
    localparam int STEP_W = $clog2(NUM_W);
    localparam int CMP_W  = (COUNT_WIDTH > DEB_W) ? COUNT_WIDTH : DEB_W;
    localparam int PEXT_W = COUNT_WIDTH + PER_W;

    localparam logic [TURN_W-1:0] FULL_TURN = TURN_W'(360);
    localparam logic [Q_W-1:0]    ANGLE_CAP = Q_W'(1023);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET   = CFG_IDX_W'(1);

    // configuration reset values
    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = DEB_W'(1000);
    localparam logic [OFS_W-1:0] OFFSET_RESET   = OFS_W'(165);

endpackage

FILE: src/rotor_period_and_angle_tracker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotor_period_and_angle_tracker_top
// Rotor period capture from the active-low magnet sensor, with the angle
// interpolated as floor(360*count/period) by a bit-serial divider.
// ----------------------------------------------------------------------------
// flow: an accepted item goes through the count update on the accepting
//   edge, 1 scaling multiply, 33 restoring divide steps and 1 load; the
//   divide steps are skipped while no period has been captured
// the input stalls until the one-bit-per-cycle divider is through and
//   the result is loaded; the next item is taken while a finished
//   result waits at the output, a stalled result holds off the next load
// reset: rst_n asynchronous active low; count and period clear, armed sets,
//   debounce limit 1000 and angle offset 165
module rotor_period_and_angle_tracker_top
    import rpat_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input item channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 sensor_level,
    // result item channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [PER_W-1:0]     period_ticks,
    output logic signed [ANG_W-1:0] angle_deg,
    output logic                 angle_valid,
    output logic                 captured,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [1:0]             state_reg, state_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [COUNT_WIDTH-1:0] period_reg, period_next;
    logic                   armed_reg, armed_next;
    logic                   cap_reg, cap_next;
    logic [DEB_W-1:0]       deb_reg;
    logic [OFS_W-1:0]       ofs_reg;

    logic [NUM_W-1:0]       num_reg, num_next;
    logic [COUNT_WIDTH-1:0] rem_reg, rem_next;
    logic [Q_W-1:0]         q_reg, q_next;
    logic                   sat_reg, sat_next;
    logic [STEP_W-1:0]      step_reg, step_next;

    logic                   out_valid_reg, out_valid_next;
    logic [PER_W-1:0]       out_per_reg, out_per_next;
    logic [ANG_W-1:0]       out_ang_reg, out_ang_next;
    logic                   out_av_reg, out_av_next;
    logic                   out_cap_reg, out_cap_next;

    logic                   accept;
    logic                   out_free;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [COUNT_WIDTH:0]   rem_sh;
    logic [COUNT_WIDTH:0]   diff;
    logic                   qbit;
    logic [Q_W-1:0]         q_final;
    logic [PEXT_W-1:0]      per_ext;
    logic                   per_nz;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // saturating tick increment
    assign count_inc = (count_reg == CNT_MAX) ? count_reg : count_reg + 1'b1;

    // one restoring divide step
    assign rem_sh = {rem_reg, num_reg[NUM_W-1]};
    assign diff   = rem_sh - {1'b0, period_reg};
    assign qbit   = !diff[COUNT_WIDTH];

    assign q_final = sat_reg ? ANGLE_CAP : q_reg;
    assign per_ext = PEXT_W'(period_reg);
    assign per_nz  = (period_reg != '0);

    // control and datapath next state
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        period_next    = period_reg;
        armed_next     = armed_reg;
        cap_next       = cap_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        sat_next       = sat_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_per_next   = out_per_reg;
        out_ang_next   = out_ang_reg;
        out_av_next    = out_av_reg;
        out_cap_next   = out_cap_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    count_next = count_inc;
                    cap_next   = 1'b0;
                    if (!sensor_level && armed_reg)
                    begin
                        period_next = count_inc;
                        count_next  = '0;
                        armed_next  = 1'b0;
                        cap_next    = 1'b1;
                    end
                    else if (sensor_level && (CMP_W'(count_inc) > CMP_W'(deb_reg)))
                    begin
                        armed_next = 1'b1;
                    end
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // scale the count by a full turn
                num_next   = NUM_W'(count_reg) * NUM_W'(FULL_TURN);
                rem_next   = '0;
                q_next     = '0;
                sat_next   = 1'b0;
                step_next  = '0;
                state_next = per_nz ? ST_DIV : ST_DONE;
            end
            ST_DIV:
            begin
                num_next = {num_reg[NUM_W-2:0], 1'b0};
                rem_next = qbit ? diff[COUNT_WIDTH-1:0] : rem_sh[COUNT_WIDTH-1:0];
                q_next   = {q_reg[Q_W-2:0], qbit};
                sat_next = sat_reg || q_reg[Q_W-1];
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(NUM_W - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // load the result once the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_per_next   = per_ext[PER_W-1:0];
                    out_av_next    = per_nz;
                    out_cap_next   = cap_reg;
                    out_ang_next   = per_nz ? (ANG_W'(q_final) - ANG_W'(ofs_reg)) : '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            period_reg    <= '0;
            armed_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
            deb_reg       <= DEBOUNCE_RESET;
            ofs_reg       <= OFFSET_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            period_reg    <= period_next;
            armed_reg     <= armed_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && (cfg_index == REG_DEBOUNCE))
            begin
                deb_reg <= cfg_data[DEB_W-1:0];
            end
            if (cfg_we && (cfg_index == REG_OFFSET))
            begin
                ofs_reg <= cfg_data[OFS_W-1:0];
            end
        end
    end

    // divider and result payload registers
    always_ff @(posedge clk)
    begin
        cap_reg     <= cap_next;
        num_reg     <= num_next;
        rem_reg     <= rem_next;
        q_reg       <= q_next;
        sat_reg     <= sat_next;
        step_reg    <= step_next;
        out_per_reg <= out_per_next;
        out_ang_reg <= out_ang_next;
        out_av_reg  <= out_av_next;
        out_cap_reg <= out_cap_next;
    end

    assign out_valid    = out_valid_reg;
    assign period_ticks = out_per_reg;
    assign angle_deg    = out_ang_reg;
    assign angle_valid  = out_av_reg;
    assign captured     = out_cap_reg;

endmodule

FILE: src/rpat_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpat_checker
// Port-level checks for the rotor period and angle tracker, bound to the top.
// ----------------------------------------------------------------------------
module rpat_checker
    import rpat_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 sensor_level,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [PER_W-1:0]     period_ticks,
    input logic signed [ANG_W-1:0] angle_deg,
    input logic                 angle_valid,
    input logic                 captured,
    input logic                 cfg_we,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [CFG_W-1:0]     cfg_data
);

    // a stalled item stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result item dropped while stalled");

    // a stalled item keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(period_ticks) && $stable(angle_deg))
        else $error("result payload changed while stalled");

    // one item at a time: after an accept the input stalls
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while an item is in flight");

    // a capture always leaves a nonzero period behind
    a_cap_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && captured |-> angle_valid && (period_ticks != '0))
        else $error("capture without a valid period");

    // no period yet means a zero angle
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !angle_valid |-> (angle_deg == '0) && (period_ticks == '0))
        else $error("angle shown without a period");

endmodule

bind rotor_period_and_angle_tracker_top rpat_checker u_rpat_checker (.*);

FILE: tb/rotor_period_and_angle_tracker_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotor_period_and_angle_tracker_top_test
// Self-checking bench for the rotor period and angle tracker. A short table
// of sensor ticks and register writes covers reset, capture, re-arm, angle
// saturation, large offsets and ignored register indexes. Random rotations
// follow under several register settings and handshake pressure modes. Every
// result item is compared with a typed table value or a cycle-free model.
// ----------------------------------------------------------------------------
module rotor_period_and_angle_tracker_top_test
    import rpat_pkg::*;
();

    localparam int RUN_LIMIT    = 1000000;
    localparam int TAIL_CYCLES  = 40;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 170;

    // register indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

    localparam logic [COUNT_WIDTH-1:0] COUNT_TOP = '1;

    typedef struct packed {
        logic [PER_W-1:0]        period;
        logic signed [ANG_W-1:0] angle;
        logic                    valid;
        logic                    cap;
    } tick_result_t;

    typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        logic                 level;
        logic                 typed;
        tick_result_t         want;
    } dir_row_t;

    localparam int DIR_ROWS = 30;

    // directed table: typed expectations only where the value is obvious
    dir_row_t dir_tab [DIR_ROWS] = '{
        // no period yet after reset
        '{ROW_TICK, REG_DEBOUNCE, '0, 1'b1, 1'b1, '{24'd0, 11'sd0, 1'b0, 1'b0}},
        '{ROW_TICK, REG_DEBOUNCE, '0, 1'b1, 1'b1, '{24'd0, 11'sd0, 1'b0, 1'b0}},
        // first capture, angle is minus the offset
        '{ROW_TICK, REG_DEBOUNCE, '0, 1'b0, 1'b1, '{24'd3, -11'sd165, 1'b1, 1'b1}},
        '{ROW_TICK, REG_DEBOUNCE, '0, 1'b1, 1'b0, '0},
        // magnet still present but disarmed
        '{ROW_TICK, REG_DEBOUNCE, '0, 1'b0, 1'b0, '0},
        '{ROW_TICK, REG_DEBOUNCE, '0, 1'b1, 1'b0, '0},
        '{ROW_TICK, REG_DEBOUNCE, '0, 1'b1, 1'b0, '0},
        '{ROW_TICK, REG_DEBOUNCE, '0, 1'b1, 1'b0, '0},
        '{ROW_TICK, REG_DEBOUNCE, '0, 1'b1, 1'b0, '0},
        '{ROW_TICK, REG_DEBOUNCE, '0, 1'b1, 1'b0, '0},
        '{ROW_TICK, REG_DEBOUNCE, '0, 1'b1, 1'b0, '0},
        // count past period, angle pinned at the cap
        '{ROW_TICK, REG_DEBOUNCE, '0, 1'b1, 1'b1, '{24'd3, 11'sd858, 1'b1, 1'b0}},
        '{ROW_CFG,  REG_DEBOUNCE, 16'h0000, 1'b0, 1'b0, '0},
        '{ROW_CFG,  REG_OFFSET,   16'h0000, 1'b0, 1'b0, '0},
        // zero debounce re-arms at once
        '{ROW_TICK, REG_DEBOUNCE, '0, 1'b1, 1'b0, '0},
        '{ROW_TICK, REG_DEBOUNCE, '0, 1'b0, 1'b1, '{24'd11, 11'sd0, 1'b1, 1'b1}},
        '{ROW_TICK, REG_DEBOUNCE, '0, 1'b0, 1'b0, '0},
        '{ROW_TICK, REG_DEBOUNCE, '0, 1'b1, 1'b0, '0},
        '{ROW_TICK, REG_DEBOUNCE, '0, 1'b0, 1'b1, '{24'd3, 11'sd0, 1'b1, 1'b1}},
        // offset beyond a full turn, unused indexes ignored
        '{ROW_CFG,  REG_OFFSET,   16'hFFFF, 1'b0, 1'b0, '0},
        '{ROW_CFG,  REG_SPARE_A,  16'h1234, 1'b0, 1'b0, '0},
        '{ROW_CFG,  REG_SPARE_B,  16'hFFFF, 1'b0, 1'b0, '0},
        '{ROW_TICK, REG_DEBOUNCE, '0, 1'b1, 1'b0, '0},
        '{ROW_TICK, REG_DEBOUNCE, '0, 1'b1, 1'b0, '0},
        '{ROW_CFG,  REG_OFFSET,   16'd359,  1'b0, 1'b0, '0},
        '{ROW_CFG,  REG_DEBOUNCE, 16'hFFFF, 1'b0, 1'b0, '0},
        // largest legal offset on a capture, then no re-arm
        '{ROW_TICK, REG_DEBOUNCE, '0, 1'b0, 1'b1, '{24'd3, -11'sd359, 1'b1, 1'b1}},
        '{ROW_TICK, REG_DEBOUNCE, '0, 1'b1, 1'b0, '0},
        '{ROW_TICK, REG_DEBOUNCE, '0, 1'b0, 1'b0, '0},
        '{ROW_TICK, REG_DEBOUNCE, '0, 1'b1, 1'b0, '0}
    };

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic                    sensor_level = 1'b1;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [PER_W-1:0]        period_ticks;
    logic signed [ANG_W-1:0] angle_deg;
    logic                    angle_valid;
    logic                    captured;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]        cfg_data = '0;

    // tracker model state
    logic [COUNT_WIDTH-1:0]  trk_count;
    logic [COUNT_WIDTH-1:0]  trk_period;
    logic                    trk_armed;
    logic [DEB_W-1:0]        trk_debounce;
    logic [OFS_W-1:0]        trk_offset;

    tick_result_t            pending_results [$];

    int fails = 0;
    int cycles = 0;
    int ticks_sent = 0;
    int captures_seen = 0;
    int capped_angles = 0;
    int reg_writes = 0;
    int idle_pct = 0;
    int stall_pct = 0;

    rotor_period_and_angle_tracker_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sensor_level (sensor_level),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .period_ticks (period_ticks),
        .angle_deg    (angle_deg),
        .angle_valid  (angle_valid),
        .captured     (captured),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // one tick of the tracker: count, capture or re-arm, then interpolate
    function automatic tick_result_t advance_tracker(input logic level);
        tick_result_t      res;
        longint unsigned   quo;
        res = '0;
        if (trk_count != COUNT_TOP)
            trk_count = trk_count + 1'b1;
        if (!level && trk_armed)
        begin
            trk_period = trk_count;
            trk_count  = '0;
            trk_armed  = 1'b0;
            res.cap    = 1'b1;
        end
        else if (level && (CMP_W'(trk_count) > CMP_W'(trk_debounce)))
        begin
            trk_armed = 1'b1;
        end
        if (trk_period != '0)
        begin
            quo = (64'(trk_count) * 64'(FULL_TURN)) / 64'(trk_period);
            if (quo > 64'(ANGLE_CAP))
            begin
                quo = 64'(ANGLE_CAP);
                capped_angles++;
            end
            res.angle = ANG_W'(quo - 64'(trk_offset));
            res.valid = 1'b1;
        end
        res.period = trk_period[PER_W-1:0];
        return res;
    endfunction

    // present one tick item and hold it until taken, then maybe go idle
    task automatic send_tick(input logic level, input logic use_want,
                             input tick_result_t want);
        tick_result_t pred;
        in_valid     <= 1'b1;
        sensor_level <= level;
        do
            @(posedge clk);
        while (in_stall);
        pred = advance_tracker(level);
        pending_results.push_back(use_want ? want : pred);
        ticks_sent++;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // let every outstanding result item drain before touching registers
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        if (idx == REG_DEBOUNCE)
            trk_debounce = data[DEB_W-1:0];
        else if (idx == REG_OFFSET)
            trk_offset = data[OFS_W-1:0];
        reg_writes++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // receiver stall pattern
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // compare each result item with the oldest expectation
    always @(posedge clk)
    begin : result_check
        tick_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result item with nothing expected: period %0d angle %0d",
                       period_ticks, angle_deg);
                fails++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (period_ticks !== want.period)
                begin
                    $error("period_ticks: expected %0d, got %0d", want.period, period_ticks);
                    fails++;
                end
                if (angle_deg !== want.angle)
                begin
                    $error("angle_deg: expected %0d, got %0d", want.angle, angle_deg);
                    fails++;
                end
                if (angle_valid !== want.valid)
                begin
                    $error("angle_valid: expected %0d, got %0d", want.valid, angle_valid);
                    fails++;
                end
                if (captured !== want.cap)
                begin
                    $error("captured: expected %0d, got %0d", want.cap, captured);
                    fails++;
                end
                if (want.cap)
                    captures_seen++;
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        int          emitted;
        int          run_len;
        int          mode;
        logic [CFG_W-1:0] deb_val;
        logic [CFG_W-1:0] ofs_val;

        trk_count    = '0;
        trk_period   = '0;
        trk_armed    = 1'b1;
        trk_debounce = DEBOUNCE_RESET;
        trk_offset   = OFFSET_RESET;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_tab[i].kind == ROW_CFG)
            begin
                drain_results();
                write_reg(dir_tab[i].idx, dir_tab[i].data);
            end
            else
            begin
                send_tick(dir_tab[i].level, dir_tab[i].typed, dir_tab[i].want);
            end
        end

        // random rotations under changing settings and pressure
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_results();
            mode = ph % 4;
            idle_pct  = (mode == 1) ? 61 : (mode == 3) ? 17 : 0;
            stall_pct = (mode == 2) ? 61 : (mode == 3) ? 17 : 0;

            case (ph)
                0:
                begin
                    deb_val = '0;
                    ofs_val = '0;
                end
                1:
                begin
                    deb_val = 16'hFFFF;
                    ofs_val = 16'd359;
                end
                2:
                begin
                    deb_val = CFG_W'($urandom_range(0, 80));
                    ofs_val = CFG_W'($urandom_range(0, 65535));
                end
                default:
                begin
                    deb_val = CFG_W'($urandom_range(0, 80));
                    ofs_val = CFG_W'($urandom_range(0, 359));
                end
            endcase
            write_reg(REG_DEBOUNCE, deb_val);
            write_reg(REG_OFFSET, ofs_val);
            if ($urandom_range(1) == 1)
                write_reg(($urandom_range(1) == 1) ? REG_SPARE_A : REG_SPARE_B,
                          CFG_W'($urandom_range(0, 65535)));

            emitted = 0;
            while (emitted < PHASE_ITEMS)
            begin
                if ($urandom_range(9) < 8)
                begin
                    // one magnet pass: absent for a while, then present
                    run_len = ($urandom_range(9) == 0) ? $urandom_range(41, 150)
                                                       : $urandom_range(1, 40);
                    for (int k = 0; k < run_len; k++)
                        send_tick(1'b1, 1'b0, '0);
                    emitted += run_len;
                    run_len = $urandom_range(1, 3);
                    for (int k = 0; k < run_len; k++)
                        send_tick(1'b0, 1'b0, '0);
                    emitted += run_len;
                end
                else
                begin
                    // sensor chatter
                    run_len = $urandom_range(1, 6);
                    for (int k = 0; k < run_len; k++)
                        send_tick(logic'($urandom_range(1)), 1'b0, '0);
                    emitted += run_len;
                end
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d ticks, %0d captures, %0d angles at the cap", ticks_sent,
                 captures_seen, capped_angles);
        $display("%0d register writes over %0d pressure phases", reg_writes, PHASES);
        if (fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: rotor_period_and_angle_tracker_top.f
src/rpat_pkg.sv
src/rotor_period_and_angle_tracker_top.sv
src/rpat_checker.sv
tb/rotor_period_and_angle_tracker_top_test.sv
